@@ src/lr_shift_reduce_parse_engine_macros.svh @@
// Assertion macros for the LR shift-reduce parse engine.
// Used by the top level; needs no other file.
`ifndef LR_SHIFT_REDUCE_PARSE_ENGINE_MACROS_SVH
`define LR_SHIFT_REDUCE_PARSE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrpe: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrpe: assertion failed");

`endif

@@ src/lrpe_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the parse engine.
// Depends on nothing; every other file but the macros header uses it by scoped names.
`default_nettype none

package lrpe_pkg;

	localparam int NUM_RULES    = 256;
	localparam int STACK_DEPTH  = 64;
	localparam int MAX_RULE_LEN = 16;
	localparam int RED_LIMIT    = 63;

	localparam int STATE_W = 8;
	localparam int SYM_W   = 7;
	localparam int RULE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int KIND_W  = 2;
	localparam int EV_W    = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int TBL_AW  = STATE_W + SYM_W;
	localparam int RULE_AW = $clog2(NUM_RULES);
	localparam int STK_AW  = $clog2(STACK_DEPTH);
	localparam int CNT_W   = STK_AW + 1;
	localparam int RED_W   = $clog2(RED_LIMIT + 1);

	typedef enum logic [1:0] {
		ACT_TBL     = 2'd0,
		ACT_RULE    = 2'd1,
		ACT_TOKEN   = 2'd2,
		ACT_RESTART = 2'd3
	} act_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_SHIFT  = 2'd1,
		KIND_GOTO   = 2'd2,
		KIND_REDUCE = 2'd3
	} kind_t;

	typedef enum logic [EV_W-1:0] {
		EV_SHIFT    = 3'd0,
		EV_REDUCE   = 3'd1,
		EV_ACCEPT   = 3'd2,
		EV_SYNTAX   = 3'd3,
		EV_OVERFLOW = 3'd4,
		EV_LIMIT    = 3'd5
	} ev_t;

	typedef enum logic [1:0] {
		FIN_RUN  = 2'd0,
		FIN_ACC  = 2'd1,
		FIN_FAIL = 2'd2
	} fin_t;

	// Operand selection for a result.
	typedef enum logic [2:0] {
		FMT_SHIFT,
		FMT_TOK,
		FMT_HEAD_BB,
		FMT_RED_EXP,
		FMT_RED_GOTO,
		FMT_CUR_ROOT,
		FMT_CUR_HEAD
	} fmt_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_ACT,
		S_RULE,
		S_POP,
		S_PUSH,
		S_GOTO,
		S_ACC,
		S_SERR
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [STATE_W-1:0] target;
	} entry_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [SYM_W-1:0] head;
	} rule_t;

	typedef struct packed {
		logic [SYM_W-1:0]   sym;
		logic [STATE_W-1:0] st;
	} stk_t;

	typedef struct packed {
		logic clear_wr;
		logic tbl_wr;
		logic rule_wr;
		logic restart;
		logic tok_ld;
		logic look_rd;
		logic goto_rd;
		logic rule_rd;
		logic stack_rd;
		logic push_shift;
		logic push_reduce;
		logic cur_goto;
		logic exp_cur;
		logic exp_stack;
		logic fin_we;
		fin_t fin_val;
		logic emit;
		ev_t  emit_ev;
		fmt_t emit_fmt;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic  running;
		logic  clear_last;
		logic  slot_free;
		kind_t kind;
		logic  red_limit;
		logic  rule_bad;
		logic  len_gt_cnt;
		logic  pop_ovf;
		logic  len_zero;
		logic  acc_shift;
		logic  acc_red;
		logic  stack_full;
	} stat_t;

endpackage

`default_nettype wire

@@ src/lrpe_cfg_regs.sv @@
// APB-style configuration register file of the parse engine (root symbol).
// Depends on lrpe_pkg.
`default_nettype none

module lrpe_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lrpe_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lrpe_pkg::PDATA_W-1:0] pwdata,
	output logic      [lrpe_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	output logic      [lrpe_pkg::SYM_W-1:0]   root
);

	logic [lrpe_pkg::SYM_W-1:0] root_q;
	logic                       sel_root;

	assign sel_root = (paddr[lrpe_pkg::PADDR_W-1] == 1'b0);
	assign pready   = 1'b1;
	assign root     = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (psel && penable && pwrite && sel_root) begin
			root_q <= pwdata[lrpe_pkg::SYM_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_root) begin
			prdata[lrpe_pkg::SYM_W-1:0] = root_q;
		end
	end

endmodule

`default_nettype wire

@@ src/lrpe_ctrl.sv @@
// Controller state machine of the parse engine: sequences lookups, pops, pushes and results.
// Depends on lrpe_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module lrpe_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [1:0]      action,
	output logic                 in_stall,
	input  wire lrpe_pkg::stat_t stat,
	output lrpe_pkg::cmd_t       cmd
);

	lrpe_pkg::state_t state_q;
	lrpe_pkg::state_t state_nx;
	lrpe_pkg::act_t   act;
	logic             take;

	assign act      = lrpe_pkg::act_t'(action);
	assign in_stall = (state_q != lrpe_pkg::S_IDLE);
	assign take     = in_valid && (state_q == lrpe_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrpe_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lrpe_pkg::S_CLEAR: begin
				if (stat.clear_last) state_nx = lrpe_pkg::S_IDLE;
			end
			lrpe_pkg::S_IDLE: begin
				if (take && act == lrpe_pkg::ACT_TOKEN && stat.running) begin
					state_nx = lrpe_pkg::S_LOOK;
				end
			end
			lrpe_pkg::S_LOOK: state_nx = lrpe_pkg::S_ACT;
			lrpe_pkg::S_ACT: begin
				if (stat.slot_free) begin
					state_nx = lrpe_pkg::S_IDLE;
					if (stat.kind == lrpe_pkg::KIND_SHIFT) begin
						if (!stat.stack_full && stat.acc_shift) state_nx = lrpe_pkg::S_ACC;
					end else if (stat.kind == lrpe_pkg::KIND_REDUCE) begin
						if (!stat.red_limit && !stat.rule_bad) state_nx = lrpe_pkg::S_RULE;
					end
				end
			end
			lrpe_pkg::S_RULE: begin
				if (stat.slot_free) begin
					if (stat.len_gt_cnt || stat.pop_ovf) state_nx = lrpe_pkg::S_IDLE;
					else if (stat.len_zero) state_nx = lrpe_pkg::S_PUSH;
					else state_nx = lrpe_pkg::S_POP;
				end
			end
			lrpe_pkg::S_POP: state_nx = lrpe_pkg::S_PUSH;
			lrpe_pkg::S_PUSH: begin
				if (stat.slot_free) begin
					state_nx = stat.acc_red ? lrpe_pkg::S_ACC : lrpe_pkg::S_GOTO;
				end
			end
			lrpe_pkg::S_GOTO: begin
				if (stat.slot_free) begin
					state_nx = (stat.kind == lrpe_pkg::KIND_GOTO) ? lrpe_pkg::S_LOOK
						: lrpe_pkg::S_SERR;
				end
			end
			lrpe_pkg::S_ACC: begin
				if (stat.slot_free) state_nx = lrpe_pkg::S_IDLE;
			end
			lrpe_pkg::S_SERR: begin
				if (stat.slot_free) state_nx = lrpe_pkg::S_IDLE;
			end
			default: state_nx = lrpe_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			lrpe_pkg::S_CLEAR: cmd.clear_wr = 1'b1;
			lrpe_pkg::S_IDLE: begin
				if (take) begin
					cmd.tbl_wr  = (act == lrpe_pkg::ACT_TBL);
					cmd.rule_wr = (act == lrpe_pkg::ACT_RULE);
					cmd.restart = (act == lrpe_pkg::ACT_RESTART);
					cmd.tok_ld  = (act == lrpe_pkg::ACT_TOKEN) && stat.running;
				end
			end
			lrpe_pkg::S_LOOK: cmd.look_rd = 1'b1;
			lrpe_pkg::S_ACT: begin
				if (stat.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_fmt  = lrpe_pkg::FMT_TOK;
					cmd.emit_ev   = lrpe_pkg::EV_SYNTAX;
					cmd.fin_we    = 1'b1;
					cmd.fin_val   = lrpe_pkg::FIN_FAIL;
					if (stat.kind == lrpe_pkg::KIND_SHIFT) begin
						if (stat.stack_full) begin
							cmd.emit_ev = lrpe_pkg::EV_OVERFLOW;
						end else begin
							cmd.push_shift = 1'b1;
							cmd.emit_fmt   = lrpe_pkg::FMT_SHIFT;
							cmd.emit_ev    = lrpe_pkg::EV_SHIFT;
							cmd.emit_last  = !stat.acc_shift;
							cmd.fin_we     = 1'b0;
						end
					end else if (stat.kind == lrpe_pkg::KIND_REDUCE) begin
						if (stat.red_limit) begin
							cmd.emit_ev = lrpe_pkg::EV_LIMIT;
						end else if (!stat.rule_bad) begin
							cmd.rule_rd = 1'b1;
							cmd.emit    = 1'b0;
							cmd.fin_we  = 1'b0;
						end
					end
				end
			end
			lrpe_pkg::S_RULE: begin
				if (stat.slot_free) begin
					if (stat.len_gt_cnt || stat.pop_ovf) begin
						cmd.emit      = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.fin_we    = 1'b1;
						cmd.fin_val   = lrpe_pkg::FIN_FAIL;
						if (stat.len_gt_cnt) begin
							cmd.emit_fmt = lrpe_pkg::FMT_TOK;
							cmd.emit_ev  = lrpe_pkg::EV_SYNTAX;
						end else begin
							cmd.emit_fmt = lrpe_pkg::FMT_HEAD_BB;
							cmd.emit_ev  = lrpe_pkg::EV_OVERFLOW;
						end
					end else if (stat.len_zero) begin
						cmd.exp_cur = 1'b1;
					end else begin
						cmd.stack_rd = 1'b1;
					end
				end
			end
			lrpe_pkg::S_POP: cmd.exp_stack = 1'b1;
			lrpe_pkg::S_PUSH: begin
				if (stat.slot_free) begin
					cmd.push_reduce = 1'b1;
					if (stat.acc_red) begin
						cmd.emit     = 1'b1;
						cmd.emit_fmt = lrpe_pkg::FMT_RED_EXP;
						cmd.emit_ev  = lrpe_pkg::EV_REDUCE;
					end else begin
						cmd.goto_rd = 1'b1;
					end
				end
			end
			lrpe_pkg::S_GOTO: begin
				if (stat.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.emit_ev = lrpe_pkg::EV_REDUCE;
					if (stat.kind == lrpe_pkg::KIND_GOTO) begin
						cmd.cur_goto = 1'b1;
						cmd.emit_fmt = lrpe_pkg::FMT_RED_GOTO;
					end else begin
						cmd.emit_fmt = lrpe_pkg::FMT_RED_EXP;
					end
				end
			end
			lrpe_pkg::S_ACC: begin
				if (stat.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_fmt  = lrpe_pkg::FMT_CUR_ROOT;
					cmd.emit_ev   = lrpe_pkg::EV_ACCEPT;
					cmd.fin_we    = 1'b1;
					cmd.fin_val   = lrpe_pkg::FIN_ACC;
				end
			end
			lrpe_pkg::S_SERR: begin
				if (stat.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_fmt  = lrpe_pkg::FMT_CUR_HEAD;
					cmd.emit_ev   = lrpe_pkg::EV_SYNTAX;
					cmd.fin_we    = 1'b1;
					cmd.fin_val   = lrpe_pkg::FIN_FAIL;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ src/lrpe_datapath.sv @@
// Datapath of the parse engine: action/goto table, rule table, parse stack and parser registers,
// plus the result register. Depends on lrpe_pkg; controlled through cmd_t.
`default_nettype none

module lrpe_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lrpe_pkg::cmd_t                cmd,
	output lrpe_pkg::stat_t                    stat,
	input  wire logic [lrpe_pkg::SYM_W-1:0]   root,
	input  wire logic [lrpe_pkg::STATE_W-1:0] state_index,
	input  wire logic [lrpe_pkg::SYM_W-1:0]   column_symbol,
	input  wire logic [lrpe_pkg::KIND_W-1:0]  entry_kind,
	input  wire logic [lrpe_pkg::STATE_W-1:0] entry_target,
	input  wire logic [lrpe_pkg::RULE_W-1:0]  rule_index,
	input  wire logic [lrpe_pkg::LEN_W-1:0]   rule_length,
	input  wire logic [lrpe_pkg::SYM_W-1:0]   rule_head,
	input  wire logic [lrpe_pkg::SYM_W-1:0]   token_type,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic      [lrpe_pkg::EV_W-1:0]    event_res,
	output logic      [lrpe_pkg::RULE_W-1:0]  rule_number,
	output logic      [lrpe_pkg::STATE_W-1:0] state_before,
	output logic      [lrpe_pkg::STATE_W-1:0] state_after,
	output logic      [lrpe_pkg::SYM_W-1:0]   event_symbol,
	output logic                               last
);

	localparam int TBL_DEPTH = 2 ** lrpe_pkg::TBL_AW;
	localparam int CW = lrpe_pkg::CNT_W;

	lrpe_pkg::entry_t tbl_mem [TBL_DEPTH];
	lrpe_pkg::rule_t  rule_mem [lrpe_pkg::NUM_RULES];
	lrpe_pkg::stk_t   stk_mem [lrpe_pkg::STACK_DEPTH];

	logic [lrpe_pkg::TBL_AW-1:0]  clr_q;
	logic [CW-1:0]                cnt_q;
	logic [lrpe_pkg::STATE_W-1:0] cur_q;
	lrpe_pkg::fin_t               fin_q;
	logic [lrpe_pkg::RED_W-1:0]   red_q;
	logic [lrpe_pkg::SYM_W-1:0]   tok_q;
	logic [lrpe_pkg::STATE_W-1:0] before_q;
	logic [lrpe_pkg::STATE_W-1:0] exposed_q;
	logic [lrpe_pkg::RULE_W-1:0]  rule_num_q;
	lrpe_pkg::entry_t             entry_q;
	lrpe_pkg::rule_t              rule_q;
	lrpe_pkg::stk_t               stk_q;

	logic                         out_valid_q;
	logic [lrpe_pkg::EV_W-1:0]    ev_q;
	logic [lrpe_pkg::RULE_W-1:0]  rule_out_q;
	logic [lrpe_pkg::STATE_W-1:0] sb_q;
	logic [lrpe_pkg::STATE_W-1:0] sa_q;
	logic [lrpe_pkg::SYM_W-1:0]   sym_q;
	logic                         last_q;

	logic [CW-1:0]                new_cnt;
	logic [lrpe_pkg::TBL_AW-1:0]  tbl_waddr;
	lrpe_pkg::entry_t             tbl_wdata;
	logic [lrpe_pkg::TBL_AW-1:0]  tbl_raddr;
	logic [lrpe_pkg::LEN_W-1:0]   len_sat;
	logic [lrpe_pkg::RULE_W-1:0]  nx_rule;
	logic [lrpe_pkg::STATE_W-1:0] nx_sb;
	logic [lrpe_pkg::STATE_W-1:0] nx_sa;
	logic [lrpe_pkg::SYM_W-1:0]   nx_sym;

	assign new_cnt = cnt_q - CW'(rule_q.len);
	assign len_sat = (rule_length > lrpe_pkg::LEN_W'(lrpe_pkg::MAX_RULE_LEN))
		? lrpe_pkg::LEN_W'(lrpe_pkg::MAX_RULE_LEN) : rule_length;

	assign tbl_waddr = cmd.clear_wr ? clr_q : {state_index, column_symbol};
	assign tbl_wdata = cmd.clear_wr ? lrpe_pkg::entry_t'('0) : {entry_kind, entry_target};
	assign tbl_raddr = cmd.goto_rd ? {exposed_q, rule_q.head} : {cur_q, tok_q};

	always_ff @(posedge clk) begin
		if (cmd.clear_wr || cmd.tbl_wr) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (cmd.look_rd || cmd.goto_rd) begin
			entry_q <= tbl_mem[tbl_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rule_wr && (int'(rule_index) < lrpe_pkg::NUM_RULES)) begin
			rule_mem[rule_index[lrpe_pkg::RULE_AW-1:0]] <= {len_sat, rule_head};
		end
		if (cmd.rule_rd) begin
			rule_q     <= rule_mem[entry_q.target[lrpe_pkg::RULE_AW-1:0]];
			rule_num_q <= entry_q.target;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_shift) begin
			stk_mem[cnt_q[lrpe_pkg::STK_AW-1:0]] <= {tok_q, cur_q};
		end else if (cmd.push_reduce) begin
			stk_mem[new_cnt[lrpe_pkg::STK_AW-1:0]] <= {rule_q.head, exposed_q};
		end
		if (cmd.stack_rd) begin
			stk_q <= stk_mem[new_cnt[lrpe_pkg::STK_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
			cur_q <= '0;
			fin_q <= lrpe_pkg::FIN_RUN;
			red_q <= '0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + lrpe_pkg::TBL_AW'(1);
			if (cmd.restart) begin
				cnt_q <= '0;
				cur_q <= '0;
				fin_q <= lrpe_pkg::FIN_RUN;
			end else begin
				if (cmd.push_shift) begin
					cnt_q <= cnt_q + CW'(1);
					cur_q <= entry_q.target;
				end else if (cmd.push_reduce) begin
					cnt_q <= new_cnt + CW'(1);
					cur_q <= exposed_q;
				end else if (cmd.cur_goto) begin
					cur_q <= entry_q.target;
				end
				if (cmd.fin_we) fin_q <= cmd.fin_val;
			end
			if (cmd.tok_ld) red_q <= '0;
			else if (cmd.rule_rd) red_q <= red_q + lrpe_pkg::RED_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tok_ld) tok_q <= token_type;
		if (cmd.look_rd) before_q <= cur_q;
		if (cmd.exp_cur) exposed_q <= cur_q;
		else if (cmd.exp_stack) exposed_q <= stk_q.st;
	end

	always_comb begin
		nx_rule = '0;
		nx_sb   = before_q;
		nx_sa   = before_q;
		nx_sym  = tok_q;
		case (cmd.emit_fmt)
			lrpe_pkg::FMT_SHIFT: nx_sa = entry_q.target;
			lrpe_pkg::FMT_TOK: nx_sa = before_q;
			lrpe_pkg::FMT_HEAD_BB: nx_sym = rule_q.head;
			lrpe_pkg::FMT_RED_EXP: begin
				nx_rule = rule_num_q;
				nx_sa   = exposed_q;
				nx_sym  = rule_q.head;
			end
			lrpe_pkg::FMT_RED_GOTO: begin
				nx_rule = rule_num_q;
				nx_sa   = entry_q.target;
				nx_sym  = rule_q.head;
			end
			lrpe_pkg::FMT_CUR_ROOT: begin
				nx_sb  = cur_q;
				nx_sa  = cur_q;
				nx_sym = root;
			end
			lrpe_pkg::FMT_CUR_HEAD: begin
				nx_sb  = cur_q;
				nx_sa  = cur_q;
				nx_sym = rule_q.head;
			end
			default: nx_sa = before_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ev_q       <= cmd.emit_ev;
			rule_out_q <= nx_rule;
			sb_q       <= nx_sb;
			sa_q       <= nx_sa;
			sym_q      <= nx_sym;
			last_q     <= cmd.emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = ev_q;
	assign rule_number  = rule_out_q;
	assign state_before = sb_q;
	assign state_after  = sa_q;
	assign event_symbol = sym_q;
	assign last         = last_q;

	always_comb begin
		stat.running    = (fin_q == lrpe_pkg::FIN_RUN);
		stat.clear_last = &clr_q;
		stat.slot_free  = !out_valid_q || !out_stall;
		stat.kind       = lrpe_pkg::kind_t'(entry_q.kind);
		stat.red_limit  = (red_q >= lrpe_pkg::RED_W'(lrpe_pkg::RED_LIMIT));
		stat.rule_bad   = (int'(entry_q.target) >= lrpe_pkg::NUM_RULES);
		stat.len_gt_cnt = (CW'(rule_q.len) > cnt_q);
		stat.pop_ovf    = (new_cnt >= CW'(lrpe_pkg::STACK_DEPTH));
		stat.len_zero   = (rule_q.len == '0);
		stat.acc_shift  = (cnt_q == '0) && (tok_q == root);
		stat.acc_red    = (new_cnt == '0) && (rule_q.head == root);
		stat.stack_full = (cnt_q >= CW'(lrpe_pkg::STACK_DEPTH));
	end

endmodule

`default_nettype wire

@@ src/lr_shift_reduce_parse_engine.sv @@
// Top level of the table-driven LR shift-reduce parse engine: controller, datapath, registers.
// Depends on lrpe_pkg, lrpe_cfg_regs, lrpe_ctrl, lrpe_datapath and the macros header.
//
// Channel   Direction  Handshake            Carries
// input     in         in_valid / in_stall  load, token and restart items
// output    out        out_valid/out_stall  one result per parser action
// config    in         APB psel/penable     root symbol at addresses 0 to 3 (paddr[2] low)
//
// A load or restart item is written in the cycle it is taken; a token is worked through the
// registered reads of the action table, rule table and stack, with in_stall high until it is done.
// After reset a clearing pass writes all 32768 action table entries, one per cycle, and
// in_stall stays high until the pass ends; configuration transfers are taken throughout.
// A stalled output holds the parser until its pending result transfer completes.
`default_nettype none
`include "lr_shift_reduce_parse_engine_macros.svh"

module lr_shift_reduce_parse_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lrpe_pkg::PADDR_W-1:0] paddr,
	input  wire logic [lrpe_pkg::PDATA_W-1:0] pwdata,
	output logic      [lrpe_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    action,
	input  wire logic [lrpe_pkg::STATE_W-1:0] state_index,
	input  wire logic [lrpe_pkg::SYM_W-1:0]   column_symbol,
	input  wire logic [lrpe_pkg::KIND_W-1:0]  entry_kind,
	input  wire logic [lrpe_pkg::STATE_W-1:0] entry_target,
	input  wire logic [lrpe_pkg::RULE_W-1:0]  rule_index,
	input  wire logic [lrpe_pkg::LEN_W-1:0]   rule_length,
	input  wire logic [lrpe_pkg::SYM_W-1:0]   rule_head,
	input  wire logic [lrpe_pkg::SYM_W-1:0]   token_type,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [lrpe_pkg::EV_W-1:0]    event_res,
	output logic      [lrpe_pkg::RULE_W-1:0]  rule_number,
	output logic      [lrpe_pkg::STATE_W-1:0] state_before,
	output logic      [lrpe_pkg::STATE_W-1:0] state_after,
	output logic      [lrpe_pkg::SYM_W-1:0]   event_symbol,
	output logic                               last
);

	lrpe_pkg::cmd_t             cmd;
	lrpe_pkg::stat_t            stat;
	logic [lrpe_pkg::SYM_W-1:0] root;

	lrpe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.root    (root)
	);

	lrpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lrpe_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.root          (root),
		.state_index   (state_index),
		.column_symbol (column_symbol),
		.entry_kind    (entry_kind),
		.entry_target  (entry_target),
		.rule_index    (rule_index),
		.rule_length   (rule_length),
		.rule_head     (rule_head),
		.token_type    (token_type),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.event_res     (event_res),
		.rule_number   (rule_number),
		.state_before  (state_before),
		.state_after   (state_after),
		.event_symbol  (event_symbol),
		.last          (last)
	);

	// A new result is only loaded when the output register is free or draining.
	`LRPE_ASSERT_IMP(a_emit_slot, clk, arst_n, cmd.emit, stat.slot_free)
	// A shift never pushes onto a full stack.
	`LRPE_ASSERT_IMP(a_push_room, clk, arst_n, cmd.push_shift, !stat.stack_full)
	// A result that is not the last of its token leaves the engine busy.
	`LRPE_ASSERT_NXT(a_mid_token_busy, clk, arst_n, cmd.emit && !cmd.emit_last, in_stall)
	// No item is taken while the clearing pass runs.
	`LRPE_ASSERT_IMP(a_clear_stall, clk, arst_n, cmd.clear_wr, in_stall)

endmodule

`default_nettype wire
